FILE: hw/rtl/rsht_pkg.sv
// Shared types, constants and register map of the RNG statistical health test.
package rsht_pkg;

	// Block geometry
	localparam int BLOCK_BYTES = 2500;
	localparam int CNT_W = 12;
	localparam logic [CNT_W-1:0] BLOCK_END_CNT = CNT_W'(BLOCK_BYTES % 4096);

	// Field widths
	localparam int CNT15_W = 15;
	localparam int BIN_W = 13;
	localparam int SQ_W = 25;
	localparam int POKER_W = 29;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [CNT15_W-1:0] MAX15 = '1;
	localparam logic [BIN_W-1:0] MAX13 = '1;
	localparam logic [SQ_W-1:0] MAX25 = '1;

	// Register indexes
	localparam logic [2:0] REG_MONO_LOW = 3'd0;
	localparam logic [2:0] REG_MONO_HIGH = 3'd1;
	localparam logic [2:0] REG_MAX_RUN = 3'd2;
	localparam logic [2:0] REG_POKER_LOW = 3'd3;
	localparam logic [2:0] REG_POKER_HIGH = 3'd4;

	// Register reset values
	localparam logic [CNT15_W-1:0] MONO_LOW_RST = 15'd9654;
	localparam logic [CNT15_W-1:0] MONO_HIGH_RST = 15'd10362;
	localparam logic [CNT15_W-1:0] MAX_RUN_RST = 15'd36;
	localparam logic [POKER_W-1:0] POKER_LOW_RST = 29'd25005150;
	localparam logic [POKER_W-1:0] POKER_HIGH_RST = 29'd25285650;

	// Configuration register set
	typedef struct packed {
		logic [CNT15_W-1:0] mono_low;
		logic [CNT15_W-1:0] mono_high;
		logic [CNT15_W-1:0] max_run;
		logic [POKER_W-1:0] poker_low;
		logic [POKER_W-1:0] poker_high;
	} cfg_t;

	// Per-byte update control for the statistics units
	typedef struct packed {
		logic take;
		logic last;
	} step_t;

endpackage

FILE: hw/rtl/rng_statistical_health_test.sv
// Top level of the RNG statistical health test: input stage, block counter, result register.
// Random bytes enter on in_valid/in_ready, one per cycle, bits taken most significant
// first; every BLOCK_BYTES bytes (2500, i.e. 20000 bits) one result request leaves on
// out_valid/out_ready carrying the ones count, both longest runs, the nibble square sum
// and the monobit, runs and poker verdicts against the APB-programmed bounds. The result
// request is registered when the input stage advances with the block's last byte; the block
// sustains one byte per cycle unless held, set by the combinational update of the run tracker
// and nibble histogram in the input stage. The input stage holds only when a block's last
// byte is due while the previous result still waits unread, so a held result can delay
// at most that one byte. Write configuration only while no block is in progress.
module rng_statistical_health_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rsht_pkg::ADDR_W-1:0]         paddr,
	input  logic [rsht_pkg::DATA_W-1:0]         pwdata,
	output logic [rsht_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                monobit_pass,
	output logic                                runs_pass,
	output logic                                poker_pass,
	output logic [rsht_pkg::CNT15_W-1:0]        ones_total,
	output logic [rsht_pkg::CNT15_W-1:0]        longest_ones,
	output logic [rsht_pkg::CNT15_W-1:0]        longest_zeros,
	output logic [rsht_pkg::SQ_W-1:0]           square_sum
);

	rsht_pkg::cfg_t  cfg;
	rsht_pkg::step_t step;

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          advance;
	logic [rsht_pkg::CNT_W-1:0]    byte_cnt_q;
	logic [rsht_pkg::CNT_W-1:0]    cnt_inc;
	logic [rsht_pkg::CNT15_W-1:0]  ones_n;
	logic [rsht_pkg::CNT15_W-1:0]  one_max_n;
	logic [rsht_pkg::CNT15_W-1:0]  zero_max_n;
	logic [rsht_pkg::SQ_W-1:0]     sq_n;
	logic                          out_valid_q;
	logic [rsht_pkg::CNT15_W-1:0]  ones_q;
	logic [rsht_pkg::CNT15_W-1:0]  one_max_q;
	logic [rsht_pkg::CNT15_W-1:0]  zero_max_q;
	logic [rsht_pkg::SQ_W-1:0]     sq_q;
	logic [rsht_pkg::POKER_W-1:0]  poker_scaled;

	rsht_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Hold the input stage only when a block's last byte meets an unread result
	assign advance = valid_s1 && (!step.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// Count bytes within the block
	assign cnt_inc = byte_cnt_q + 1'b1;
	assign step.take = advance;
	assign step.last = cnt_inc == rsht_pkg::BLOCK_END_CNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (advance) begin
			byte_cnt_q <= step.last ? '0 : cnt_inc;
		end
	end

	rsht_bit_stats u_bits (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data       (byte_s1),
		.ones_n     (ones_n),
		.one_max_n  (one_max_n),
		.zero_max_n (zero_max_n)
	);

	rsht_nibble_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (byte_s1),
		.sq_n   (sq_n)
	);

	// Load the result at block end; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.last) begin
			ones_q <= ones_n;
			one_max_q <= one_max_n;
			zero_max_q <= zero_max_n;
			sq_q <= sq_n;
		end
	end

	// Verdicts against the configured bounds
	assign poker_scaled = {sq_q, 4'b0000};
	assign monobit_pass = (ones_q >= cfg.mono_low) && (ones_q <= cfg.mono_high);
	assign runs_pass = (one_max_q <= cfg.max_run) && (zero_max_q <= cfg.max_run);
	assign poker_pass = (poker_scaled > cfg.poker_low) && (poker_scaled < cfg.poker_high);

	assign out_valid = out_valid_q;
	assign ones_total = ones_q;
	assign longest_ones = one_max_q;
	assign longest_zeros = zero_max_q;
	assign square_sum = sq_q;

	// The block counter restarts after every result load
	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step.last) |=> (byte_cnt_q == '0))
		else $error("byte counter not cleared at block end");

	// No ones means no run of ones
	a_no_ones_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ones_q == '0) |-> (one_max_q == '0))
		else $error("run of ones reported without any one bits");

	// A held input stage keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage lost a held byte");

endmodule

FILE: hw/rtl/rsht_apb_regs.sv
// APB configuration registers of the RNG statistical health test.
module rsht_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rsht_pkg::ADDR_W-1:0]  paddr,
	input  logic [rsht_pkg::DATA_W-1:0]  pwdata,
	output logic [rsht_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output rsht_pkg::cfg_t               cfg
);

	rsht_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// Write the addressed register; ignore addresses past the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mono_low <= rsht_pkg::MONO_LOW_RST;
			cfg_q.mono_high <= rsht_pkg::MONO_HIGH_RST;
			cfg_q.max_run <= rsht_pkg::MAX_RUN_RST;
			cfg_q.poker_low <= rsht_pkg::POKER_LOW_RST;
			cfg_q.poker_high <= rsht_pkg::POKER_HIGH_RST;
		end else if (wr_en) begin
			case (idx)
				rsht_pkg::REG_MONO_LOW: cfg_q.mono_low <= pwdata[rsht_pkg::CNT15_W-1:0];
				rsht_pkg::REG_MONO_HIGH: cfg_q.mono_high <= pwdata[rsht_pkg::CNT15_W-1:0];
				rsht_pkg::REG_MAX_RUN: cfg_q.max_run <= pwdata[rsht_pkg::CNT15_W-1:0];
				rsht_pkg::REG_POKER_LOW: cfg_q.poker_low <= pwdata[rsht_pkg::POKER_W-1:0];
				rsht_pkg::REG_POKER_HIGH: cfg_q.poker_high <= pwdata[rsht_pkg::POKER_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			rsht_pkg::REG_MONO_LOW: prdata = rsht_pkg::DATA_W'(cfg_q.mono_low);
			rsht_pkg::REG_MONO_HIGH: prdata = rsht_pkg::DATA_W'(cfg_q.mono_high);
			rsht_pkg::REG_MAX_RUN: prdata = rsht_pkg::DATA_W'(cfg_q.max_run);
			rsht_pkg::REG_POKER_LOW: prdata = rsht_pkg::DATA_W'(cfg_q.poker_low);
			rsht_pkg::REG_POKER_HIGH: prdata = rsht_pkg::DATA_W'(cfg_q.poker_high);
			default: prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/rsht_bit_stats.sv
// Ones count and longest-run tracking over the bits of each byte.
module rsht_bit_stats (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsht_pkg::step_t               step,
	input  logic [7:0]                    data,
	output logic [rsht_pkg::CNT15_W-1:0]  ones_n,
	output logic [rsht_pkg::CNT15_W-1:0]  one_max_n,
	output logic [rsht_pkg::CNT15_W-1:0]  zero_max_n
);

	logic [rsht_pkg::CNT15_W-1:0] ones_q;
	logic                         run_bit_q;
	logic [rsht_pkg::CNT15_W-1:0] run_len_q;
	logic [rsht_pkg::CNT15_W-1:0] one_max_q;
	logic [rsht_pkg::CNT15_W-1:0] zero_max_q;
	logic                         run_bit_n;
	logic [rsht_pkg::CNT15_W-1:0] run_len_n;

	// Walk the eight bits, most significant first
	always_comb begin
		ones_n = ones_q;
		run_bit_n = run_bit_q;
		run_len_n = run_len_q;
		one_max_n = one_max_q;
		zero_max_n = zero_max_q;
		for (int j = 7; j >= 0; j--) begin
			if (data[j] && ones_n != rsht_pkg::MAX15) begin
				ones_n = ones_n + 1'b1;
			end
			if (run_len_n != '0 && data[j] == run_bit_n) begin
				if (run_len_n != rsht_pkg::MAX15) begin
					run_len_n = run_len_n + 1'b1;
				end
			end else begin
				run_bit_n = data[j];
				run_len_n = rsht_pkg::CNT15_W'(1);
			end
			if (data[j]) begin
				if (run_len_n > one_max_n) begin
					one_max_n = run_len_n;
				end
			end else begin
				if (run_len_n > zero_max_n) begin
					zero_max_n = run_len_n;
				end
			end
		end
	end

	// Advance on each byte; clear at block end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_q <= '0;
			run_bit_q <= 1'b0;
			run_len_q <= '0;
			one_max_q <= '0;
			zero_max_q <= '0;
		end else if (step.take) begin
			if (step.last) begin
				ones_q <= '0;
				run_bit_q <= 1'b0;
				run_len_q <= '0;
				one_max_q <= '0;
				zero_max_q <= '0;
			end else begin
				ones_q <= ones_n;
				run_bit_q <= run_bit_n;
				run_len_q <= run_len_n;
				one_max_q <= one_max_n;
				zero_max_q <= zero_max_n;
			end
		end
	end

endmodule

FILE: hw/rtl/rsht_nibble_hist.sv
// Nibble histogram and running sum of squared bin counts.
module rsht_nibble_hist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsht_pkg::step_t            step,
	input  logic [7:0]                 data,
	output logic [rsht_pkg::SQ_W-1:0]  sq_n
);

	logic [rsht_pkg::BIN_W-1:0] bins_q [16];
	logic [rsht_pkg::BIN_W-1:0] bins_n [16];
	logic [rsht_pkg::SQ_W-1:0]  sq_q;
	logic [3:0]                 hi;
	logic [3:0]                 lo;
	logic [rsht_pkg::BIN_W-1:0] c_hi;
	logic [rsht_pkg::BIN_W-1:0] c_hi_n;
	logic [rsht_pkg::BIN_W-1:0] c_lo;
	logic [rsht_pkg::BIN_W-1:0] c_lo_n;
	logic                       hi_ok;
	logic                       lo_ok;
	logic [rsht_pkg::BIN_W:0]   d_hi;
	logic [rsht_pkg::BIN_W:0]   d_lo;
	logic [rsht_pkg::SQ_W:0]    sq_sum;

	assign hi = data[7:4];
	assign lo = data[3:0];

	// Bump the high-nibble bin, then the low-nibble bin seeing that update
	assign c_hi = bins_q[hi];
	assign hi_ok = c_hi != rsht_pkg::MAX13;
	assign c_hi_n = c_hi + rsht_pkg::BIN_W'(hi_ok);
	assign c_lo = (lo == hi) ? c_hi_n : bins_q[lo];
	assign lo_ok = c_lo != rsht_pkg::MAX13;
	assign c_lo_n = c_lo + rsht_pkg::BIN_W'(lo_ok);

	// Each increment from c adds 2c+1; saturate the sum
	assign d_hi = hi_ok ? {c_hi, 1'b1} : '0;
	assign d_lo = lo_ok ? {c_lo, 1'b1} : '0;
	assign sq_sum = {1'b0, sq_q} + (rsht_pkg::SQ_W + 1)'(d_hi)
		+ (rsht_pkg::SQ_W + 1)'(d_lo);
	assign sq_n = sq_sum[rsht_pkg::SQ_W] ? rsht_pkg::MAX25 : sq_sum[rsht_pkg::SQ_W-1:0];

	// Next bin values, low nibble last
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (lo == 4'(i)) begin
				bins_n[i] = c_lo_n;
			end else if (hi == 4'(i)) begin
				bins_n[i] = c_hi_n;
			end else begin
				bins_n[i] = bins_q[i];
			end
		end
	end

	// Advance on each byte; clear at block end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= '0;
			for (int i = 0; i < 16; i++) begin
				bins_q[i] <= '0;
			end
		end else if (step.take) begin
			if (step.last) begin
				sq_q <= '0;
				for (int i = 0; i < 16; i++) begin
					bins_q[i] <= '0;
				end
			end else begin
				sq_q <= sq_n;
				for (int i = 0; i < 16; i++) begin
					bins_q[i] <= bins_n[i];
				end
			end
		end
	end

endmodule

FILE: tb/testbench.sv
// Testbench for the RNG statistical health test: block statistics predictor, stimulus and checks.
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 11;
	localparam int DIR_ROWS = 6;
	localparam int SET_COUNT = 6;
	localparam int BLOCKS_PER_SET = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 30000;
	localparam logic [2:0] REG_FIRST_SPARE = rsht_pkg::REG_POKER_HIGH + 3'd1;
	localparam logic [2:0] REG_LAST_SPARE = 3'd7;

	// One block verdict, as the result request carries it
	typedef struct packed {
		logic                         monobit_pass;
		logic                         runs_pass;
		logic                         poker_pass;
		logic [rsht_pkg::CNT15_W-1:0] ones_total;
		logic [rsht_pkg::CNT15_W-1:0] longest_ones;
		logic [rsht_pkg::CNT15_W-1:0] longest_zeros;
		logic [rsht_pkg::SQ_W-1:0]    square_sum;
	} verdict_t;

	typedef enum logic [1:0] {FILL_CONST, FILL_RAMP, FILL_RANDOM} fill_t;

	typedef struct packed {
		fill_t       kind;
		logic [7:0]  fill;
		logic        typed;
		verdict_t    v;
	} block_row_t;

	typedef enum logic [2:0] {
		GEN_UNIFORM, GEN_BIASED, GEN_RUNS, GEN_FEW_NIBBLES, GEN_CONST
	} gen_t;

	typedef enum logic [2:0] {
		SET_NEAR, SET_ALL_FAIL, SET_ALL_PASS, SET_RANGE_EDGE, SET_WIDE, SET_RESET
	} thr_mode_t;

	// Directed blocks under reset thresholds; constant fills have verdicts read off by hand
	block_row_t dir_table [DIR_ROWS] = '{
		'{FILL_CONST, 8'h00, 1'b1,
			'{1'b0, 1'b0, 1'b0, 15'd0, 15'd0, 15'd20000, 25'd25000000}},
		'{FILL_CONST, 8'hFF, 1'b1,
			'{1'b0, 1'b0, 1'b0, 15'd20000, 15'd20000, 15'd0, 25'd25000000}},
		'{FILL_CONST, 8'h0F, 1'b1,
			'{1'b1, 1'b1, 1'b0, 15'd10000, 15'd4, 15'd4, 25'd12500000}},
		'{FILL_CONST, 8'hAA, 1'b1,
			'{1'b1, 1'b1, 1'b0, 15'd10000, 15'd1, 15'd1, 25'd25000000}},
		'{FILL_RAMP, 8'h00, 1'b0, '0},
		'{FILL_RANDOM, 8'h00, 1'b0, '0}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [rsht_pkg::ADDR_W-1:0]   paddr = '0;
	logic [rsht_pkg::DATA_W-1:0]   pwdata = '0;
	logic [rsht_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [7:0]                    data_byte = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          monobit_pass;
	logic                          runs_pass;
	logic                          poker_pass;
	logic [rsht_pkg::CNT15_W-1:0]  ones_total;
	logic [rsht_pkg::CNT15_W-1:0]  longest_ones;
	logic [rsht_pkg::CNT15_W-1:0]  longest_zeros;
	logic [rsht_pkg::SQ_W-1:0]     square_sum;

	// Idling control shared by both sides
	logic calm = 1'b0;
	logic rand_part = 1'b0;
	logic hold_rx = 1'b0;

	// Threshold registers and block statistics as the predictor sees them
	rsht_pkg::cfg_t                thr;
	logic [rsht_pkg::CNT_W-1:0]    byte_idx;
	logic [rsht_pkg::CNT15_W-1:0]  bits_one;
	logic                          run_val;
	logic [rsht_pkg::CNT15_W-1:0]  run_len;
	logic [rsht_pkg::CNT15_W-1:0]  top_one_run;
	logic [rsht_pkg::CNT15_W-1:0]  top_zero_run;
	logic [rsht_pkg::BIN_W-1:0]    nib_hist [16];
	logic [rsht_pkg::SQ_W-1:0]     sq_acc;

	verdict_t pending_verdicts [$];

	// Random byte shaping, chosen per block
	int         bias_pct;
	logic       bias_up;
	logic [3:0] few_nibs [4];
	int         few_cnt;
	logic [7:0] const_fill;
	int         run_left;
	logic [7:0] run_fill;

	int err_cnt = 0;
	int blocks_sent = 0;
	int results_seen = 0;
	int stall_cycles = 0;
	int sets_applied = 0;

	rng_statistical_health_test u_dut (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	initial begin
		#16ms;
		$display("** rng_statistical_health_test: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_block_state();
		byte_idx = '0;
		bits_one = '0;
		run_val = 1'b0;
		run_len = '0;
		top_one_run = '0;
		top_zero_run = '0;
		for (int i = 0; i < 16; i++)
			nib_hist[i] = '0;
		sq_acc = '0;
	endfunction

	// Bump one nibble bin and add 2c+1 to the square sum, both saturating
	function automatic void tally_nibble(input logic [3:0] n);
		logic [rsht_pkg::BIN_W-1:0] c;
		logic [rsht_pkg::SQ_W+1:0]  s;
		c = nib_hist[n];
		if (c == rsht_pkg::MAX13)
			return;
		nib_hist[n] = c + 1'b1;
		s = (rsht_pkg::SQ_W+2)'(sq_acc) + ((rsht_pkg::SQ_W+2)'(c) << 1) + 1'b1;
		sq_acc = (s > (rsht_pkg::SQ_W+2)'(rsht_pkg::MAX25)) ? rsht_pkg::MAX25
			: s[rsht_pkg::SQ_W-1:0];
	endfunction

	// Fold one byte into the block statistics; returns 1 with the verdict at block end
	function automatic bit absorb_byte(input logic [7:0] b, output verdict_t v);
		logic                         x;
		logic [rsht_pkg::POKER_W-1:0] scaled;
		v = '0;
		for (int j = 7; j >= 0; j--) begin
			x = b[j];
			if (x && bits_one != rsht_pkg::MAX15)
				bits_one = bits_one + 1'b1;
			if (run_len != '0 && x == run_val) begin
				if (run_len != rsht_pkg::MAX15)
					run_len = run_len + 1'b1;
			end else begin
				run_val = x;
				run_len = rsht_pkg::CNT15_W'(1);
			end
			if (x) begin
				if (run_len > top_one_run)
					top_one_run = run_len;
			end else if (run_len > top_zero_run) begin
				top_zero_run = run_len;
			end
		end
		tally_nibble(b[7:4]);
		tally_nibble(b[3:0]);
		byte_idx = byte_idx + 1'b1;
		if (byte_idx != rsht_pkg::BLOCK_END_CNT)
			return 1'b0;
		scaled = {sq_acc, 4'b0000};
		v.monobit_pass = (bits_one >= thr.mono_low) && (bits_one <= thr.mono_high);
		v.runs_pass = (top_one_run <= thr.max_run) && (top_zero_run <= thr.max_run);
		v.poker_pass = (scaled > thr.poker_low) && (scaled < thr.poker_high);
		v.ones_total = bits_one;
		v.longest_ones = top_one_run;
		v.longest_zeros = top_zero_run;
		v.square_sum = sq_acc;
		clear_block_state();
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- configuration port

	// Setup then access; psel stays high so transfers can run back to back
	task automatic apb_xfer(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
	endtask

	function automatic logic [31:0] with_junk(input logic [31:0] val, input int width);
		logic [31:0] m;
		m = (32'h1 << width) - 1;
		return ($urandom() & ~m) | (val & m);
	endfunction

	// Write one register with junk above its width and track the masked value
	task automatic set_register(input logic [2:0] idx, input logic [31:0] val, input int width);
		logic [31:0] data;
		logic [31:0] unused;
		data = with_junk(val, width);
		apb_xfer(idx, 1'b1, data, unused);
		case (idx)
			rsht_pkg::REG_MONO_LOW:   thr.mono_low = data[rsht_pkg::CNT15_W-1:0];
			rsht_pkg::REG_MONO_HIGH:  thr.mono_high = data[rsht_pkg::CNT15_W-1:0];
			rsht_pkg::REG_MAX_RUN:    thr.max_run = data[rsht_pkg::CNT15_W-1:0];
			rsht_pkg::REG_POKER_LOW:  thr.poker_low = data[rsht_pkg::POKER_W-1:0];
			rsht_pkg::REG_POKER_HIGH: thr.poker_high = data[rsht_pkg::POKER_W-1:0];
			default: ;
		endcase
	endtask

	// Read every register back, then drop the bus
	task automatic check_registers();
		logic [31:0] got;
		logic [31:0] want;
		for (int r = rsht_pkg::REG_MONO_LOW; r <= rsht_pkg::REG_POKER_HIGH; r++) begin
			apb_xfer(3'(r), 1'b0, '0, got);
			case (3'(r))
				rsht_pkg::REG_MONO_LOW:   want = 32'(thr.mono_low);
				rsht_pkg::REG_MONO_HIGH:  want = 32'(thr.mono_high);
				rsht_pkg::REG_MAX_RUN:    want = 32'(thr.max_run);
				rsht_pkg::REG_POKER_LOW:  want = 32'(thr.poker_low);
				default:                  want = 32'(thr.poker_high);
			endcase
			if (got !== want) begin
				$error("register %0d: expected %0d, got %0d", r, want, got);
				err_cnt++;
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_thresholds(input thr_mode_t mode);
		rsht_pkg::cfg_t nxt;
		logic [127:0]   wide;
		logic [31:0]    unused;
		case (mode)
			SET_NEAR: begin
				nxt.mono_low = rsht_pkg::CNT15_W'($urandom_range(9500, 10000));
				nxt.mono_high = rsht_pkg::CNT15_W'($urandom_range(10000, 10500));
				nxt.max_run = rsht_pkg::CNT15_W'($urandom_range(8, 40));
				nxt.poker_low = rsht_pkg::POKER_W'($urandom_range(24990000, 25080000));
				nxt.poker_high = rsht_pkg::POKER_W'($urandom_range(25060000, 25300000));
			end
			SET_ALL_FAIL: nxt = {15'h7FFF, 15'd0, 15'd0, 29'h1FFFFFFF, 29'd0};
			SET_ALL_PASS: nxt = {15'd0, 15'h7FFF, 15'h7FFF, 29'd0, 29'h1FFFFFFF};
			SET_RANGE_EDGE: nxt = {15'd20000, 15'd20000, 15'd20000, 29'd400000000,
				29'd400000000};
			SET_WIDE: begin
				wide = {$urandom(), $urandom(), $urandom(), $urandom()};
				nxt = wide[$bits(rsht_pkg::cfg_t)-1:0];
			end
			default: nxt = {rsht_pkg::MONO_LOW_RST, rsht_pkg::MONO_HIGH_RST,
				rsht_pkg::MAX_RUN_RST, rsht_pkg::POKER_LOW_RST, rsht_pkg::POKER_HIGH_RST};
		endcase
		set_register(rsht_pkg::REG_MONO_LOW, 32'(nxt.mono_low), rsht_pkg::CNT15_W);
		set_register(rsht_pkg::REG_MONO_HIGH, 32'(nxt.mono_high), rsht_pkg::CNT15_W);
		set_register(rsht_pkg::REG_MAX_RUN, 32'(nxt.max_run), rsht_pkg::CNT15_W);
		set_register(rsht_pkg::REG_POKER_LOW, 32'(nxt.poker_low), rsht_pkg::POKER_W);
		set_register(rsht_pkg::REG_POKER_HIGH, 32'(nxt.poker_high), rsht_pkg::POKER_W);
		// Addresses past the map must leave every threshold alone
		for (int r = REG_FIRST_SPARE; r <= REG_LAST_SPARE; r++)
			apb_xfer(3'(r), 1'b1, $urandom(), unused);
		check_registers();
		sets_applied++;
	endtask

	// ---------------------------------------------------------------- byte requests

	// Offer one byte, hold it until taken, then predict
	task automatic send_byte(input logic [7:0] b, input logic typed, input verdict_t typed_v);
		verdict_t v;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			stall_cycles++;
			@(posedge clk);
		end
		if (absorb_byte(b, v)) begin
			pending_verdicts = {pending_verdicts, (typed ? typed_v : v)};
			blocks_sent++;
		end
	endtask

	function automatic logic [7:0] shaped_byte(input gen_t mode);
		logic [7:0] u;
		u = 8'($urandom());
		case (mode)
			GEN_BIASED: begin
				if ($urandom_range(0, 63) < bias_pct)
					u = bias_up ? (u | 8'($urandom())) : (u & 8'($urandom()));
			end
			GEN_RUNS: begin
				if (run_left == 0 && $urandom_range(0, 63) == 0) begin
					run_left = $urandom_range(1, 8);
					run_fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
				if (run_left > 0) begin
					run_left--;
					u = run_fill;
				end
			end
			GEN_FEW_NIBBLES: u = {few_nibs[$urandom_range(0, few_cnt - 1)],
				few_nibs[$urandom_range(0, few_cnt - 1)]};
			GEN_CONST: u = const_fill;
			default: ;
		endcase
		return u;
	endfunction

	task automatic send_random_block(input gen_t mode);
		bias_pct = $urandom_range(0, 20);
		bias_up = $urandom_range(0, 1);
		few_cnt = $urandom_range(1, 4);
		for (int i = 0; i < 4; i++)
			few_nibs[i] = 4'($urandom());
		const_fill = 8'($urandom());
		run_left = 0;
		for (int i = 0; i < rsht_pkg::BLOCK_BYTES; i++)
			send_byte(shaped_byte(mode), 1'b0, '0);
	endtask

	// Drop valid, wait for every verdict, then let the pipeline settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] b;
		clear_block_state();
		thr = {rsht_pkg::MONO_LOW_RST, rsht_pkg::MONO_HIGH_RST, rsht_pkg::MAX_RUN_RST,
			rsht_pkg::POKER_LOW_RST, rsht_pkg::POKER_HIGH_RST};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		check_registers();

		// Walk the directed table, one block per row
		for (int r = 0; r < DIR_ROWS; r++) begin
			calm <= ($urandom_range(0, 3) == 0);
			for (int i = 0; i < rsht_pkg::BLOCK_BYTES; i++) begin
				case (dir_table[r].kind)
					FILL_CONST: b = dir_table[r].fill;
					FILL_RAMP:  b = 8'(i);
					default:    b = 8'($urandom());
				endcase
				send_byte(b, dir_table[r].typed, dir_table[r].v);
			end
		end
		drain_results();

		// Random blocks under each threshold setting; the last setting runs without idling
		for (int s = 0; s < SET_COUNT; s++) begin
			apply_thresholds(thr_mode_t'(s));
			if (s == 0)
				rand_part <= 1'b1;
			for (int k = 0; k < BLOCKS_PER_SET; k++) begin
				calm <= (s == SET_COUNT - 1) || ($urandom_range(0, 3) == 0);
				send_random_block(gen_t'($urandom_range(0, 4)));
			end
			drain_results();
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", pending_verdicts.size());
			err_cnt++;
		end
		$display("covered %0d blocks of %0d bytes under %0d threshold settings",
			blocks_sent, rsht_pkg::BLOCK_BYTES, sets_applied);
		$display("%0d verdicts checked; input held back %0d cycles", results_seen,
			stall_cycles);
		if (err_cnt == 0)
			$display("** rng_statistical_health_test: PASSED **");
		else
			$display("** rng_statistical_health_test: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- result side

	// Hold off the receiver across two blocks so a finished block backs up the input
	initial begin : long_hold
		wait (rand_part);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	initial begin : receiver
		int       rx_gap;
		verdict_t want;
		rx_gap = 0;
		forever begin
			@(posedge clk);
			// Check an accepted result request against the oldest verdict
			if (out_valid === 1'b1 && out_ready) begin
				results_seen++;
				if (pending_verdicts.size() == 0) begin
					$error("result request with no verdict waiting");
					err_cnt++;
				end else begin
					want = pending_verdicts.pop_front();
					compare_field("monobit_pass", 32'(want.monobit_pass), 32'(monobit_pass));
					compare_field("runs_pass", 32'(want.runs_pass), 32'(runs_pass));
					compare_field("poker_pass", 32'(want.poker_pass), 32'(poker_pass));
					compare_field("ones_total", 32'(want.ones_total), 32'(ones_total));
					compare_field("longest_ones", 32'(want.longest_ones), 32'(longest_ones));
					compare_field("longest_zeros", 32'(want.longest_zeros),
						32'(longest_zeros));
					compare_field("square_sum", 32'(want.square_sum), 32'(square_sum));
				end
			end
			// Drive ready for the next edge
			if (hold_rx) begin
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				out_ready <= 1'b0;
				rx_gap--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				rx_gap = $urandom_range(1, 4) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

endmodule
